// ===== design/tdds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table DDS package
// Shared constants and codes for the table-driven waveform generator.
// ----------------------------------------------------------------------------
package tdds_pkg;

  // Default sizes of the generator.
  localparam int TABLE_DEPTH_DEF  = 4096;
  localparam int ACC_WIDTH_DEF    = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed widths of the configuration registers.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int STEP_W      = 32;
  localparam int AMP_W       = 16;
  localparam int OFFSET_W    = 16;

  // Amplitude is Q1.15, so the product drops 15 fraction bits.
  localparam int Q_SHIFT = 15;

  // Item kinds carried on the input tuser.
  localparam int CMD_W = 2;
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_WRITE       = 2'd1,
    CMD_PHASE_RESET = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE     = 2'd0,
    REG_FREQ_WORD  = 2'd1,
    REG_AMPLITUDE  = 2'd2,
    REG_OFFSET     = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== design/tdds_wave_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waveform table RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module tdds_wave_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/tdds_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table DDS scaler
// Multiplies a table sample by the Q1.15 amplitude, then shifts, adds the
// offset and saturates into the output register. Two elastic stages.
// ----------------------------------------------------------------------------
module tdds_scaler #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        in_sample,
  input  wire logic        [IDX_W-1:0]               in_index,
  input  wire logic signed [tdds_pkg::AMP_W-1:0]     amplitude,
  input  wire logic signed [tdds_pkg::OFFSET_W-1:0]  offset,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]             out_sample,
  output logic        [IDX_W-1:0]                    out_index
);
  import tdds_pkg::*;

  localparam int PROD_W   = SAMPLE_WIDTH + AMP_W;
  localparam int SCALED_W = PROD_W - Q_SHIFT;
  localparam int SUM_W    = ((SCALED_W > OFFSET_W) ? SCALED_W : OFFSET_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic                        prod_valid;
  logic signed [PROD_W-1:0]    prod;
  logic        [IDX_W-1:0]     prod_index;
  logic                        out_load;
  logic signed [PROD_W-1:0]    prod_next;
  logic signed [SCALED_W-1:0]  scaled;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SAMPLE_WIDTH-1:0] sample_next;

  // Stage handshakes: each stage moves when the one after it has room.
  assign out_load = prod_valid && (!out_valid || out_ready);
  assign in_ready = !prod_valid || out_load;

  // Multiply; the register after it keeps the multiplier alone in its path.
  assign prod_next = in_sample * amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      prod       <= prod_next;
      prod_index <= in_index;
    end
  end

  // Floor shift by the fraction width, add the offset and clamp.
  assign scaled = prod[PROD_W-1:Q_SHIFT];
  assign sum    = SUM_W'(scaled) + SUM_W'(offset);

  always_comb begin
    if (sum > SAT_HI) begin
      sample_next = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      sample_next = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sample_next = sum[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_sample <= sample_next;
      out_index  <= prod_index;
    end
  end

  // A product waiting on a full output stage is not lost or altered.
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_valid && !out_load |=> prod_valid && $stable(prod) && $stable(prod_index))
    else $error("product stage changed while stalled");

  // The output stage only fills from a waiting product.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && out_valid |-> $past(prod_valid))
    else $error("output became valid without a product");

endmodule
`default_nettype wire

// ===== design/table_dds_waveform_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table DDS waveform generator
// Phase accumulator driving a waveform table, scaled by amplitude and offset.
// ----------------------------------------------------------------------------
// The generator accepts one input transaction per clock cycle when the output
// side keeps up. A tick command, while enabled, produces one sample on the
// output: the table RAM read register loads on the accepting edge, then the
// sample passes through the multiplier register and the output register.
// Write and phase reset commands produce no output transaction. The table
// has no reset and no clearing pass; software loads every entry it will use
// before enabling.
// TABLE_DEPTH must be a power of two.
module table_dds_waveform_generator #(
  parameter int TABLE_DEPTH  = tdds_pkg::TABLE_DEPTH_DEF,
  parameter int ACC_WIDTH    = tdds_pkg::ACC_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = tdds_pkg::SAMPLE_WIDTH_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH),
  localparam int IN_DATA_W   = IDX_W + SAMPLE_WIDTH,
  localparam int S_TDATA_W   = ((IN_DATA_W + 7) / 8) * 8,
  localparam int OUT_DATA_W  = SAMPLE_WIDTH + IDX_W,
  localparam int M_TDATA_W   = ((OUT_DATA_W + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: wave_addr, wave_sample (lowest bit first)
  input  wire logic [S_TDATA_W-1:0]                s_axis_tdata,
  // tuser: cmd
  input  wire logic [tdds_pkg::CMD_W-1:0]          s_axis_tuser,
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: sample_out, table_index (lowest bit first)
  output logic [M_TDATA_W-1:0]                     m_axis_tdata,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [tdds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tdds_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tdds_pkg::*;

  // Configuration registers.
  logic                        enable;
  logic [STEP_W-1:0]           freq_word;
  logic signed [AMP_W-1:0]     amplitude;
  logic signed [OFFSET_W-1:0]  offset;

  logic [ACC_WIDTH-1:0]        phase_acc;
  logic [ACC_WIDTH-1:0]        step_ext;
  logic                        accept;
  cmd_t                        cmd;
  logic                        tick_go;
  logic                        write_go;
  logic                        phase_clr;
  logic [IDX_W-1:0]            rd_index;

  logic                        rd_valid;
  logic [IDX_W-1:0]            rd_index_q;
  logic [SAMPLE_WIDTH-1:0]     rd_sample;
  logic                        rd_ready;
  logic                        scl_ready;

  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic        [IDX_W-1:0]        out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      freq_word  <= '0;
      amplitude  <= '0;
      offset     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_FREQ_WORD:  freq_word  <= cfg_data[STEP_W-1:0];
        REG_AMPLITUDE:  amplitude  <= cfg_data[AMP_W-1:0];
        REG_OFFSET:     offset     <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode for the accepted transaction.
  assign cmd           = cmd_t'(s_axis_tuser);
  assign s_axis_tready = rd_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick_go       = accept && (cmd == CMD_TICK) && enable;
  assign write_go      = accept && (cmd == CMD_WRITE);
  assign phase_clr     = accept && (cmd == CMD_PHASE_RESET);

  // Phase accumulator; its top bits address the table.
  assign step_ext = ACC_WIDTH'(freq_word);
  assign rd_index = phase_acc[ACC_WIDTH-1 -: IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (phase_clr) begin
      phase_acc <= '0;
    end else if (tick_go) begin
      phase_acc <= phase_acc + step_ext;
    end
  end

  // Table read stage.
  assign rd_ready = !rd_valid || scl_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_ready) begin
      rd_valid <= tick_go;
    end
    if (tick_go) begin
      rd_index_q <= rd_index;
    end
  end

  tdds_wave_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SAMPLE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (write_go),
    .waddr (s_axis_tdata[IDX_W-1:0]),
    .wdata (s_axis_tdata[IN_DATA_W-1:IDX_W]),
    .re    (tick_go),
    .raddr (rd_index),
    .rdata (rd_sample)
  );

  tdds_scaler #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_scaler (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rd_valid),
    .in_ready   (scl_ready),
    .in_sample  (rd_sample),
    .in_index   (rd_index_q),
    .amplitude  (amplitude),
    .offset     (offset),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (out_sample),
    .out_index  (out_index)
  );

  // Output packing with zero fill to whole bytes.
  assign m_axis_tdata = M_TDATA_W'({out_index, out_sample});

  // An enabled tick advances the phase by exactly one step.
  a_phase_adv: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> phase_acc == $past(phase_acc) + $past(step_ext))
    else $error("phase did not advance by one step");

  // A phase reset command clears the accumulator.
  a_phase_clr: assert property (@(posedge clk) disable iff (rst)
    phase_clr |=> phase_acc == '0)
    else $error("phase reset did not clear the accumulator");

  // Without a tick or a phase reset the accumulator holds.
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_go && !phase_clr |=> $stable(phase_acc))
    else $error("phase changed without a command");

  // A read result stalled by the scaler keeps its index.
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !scl_ready |=> rd_valid && $stable(rd_index_q))
    else $error("table read stage changed while stalled");

endmodule
`default_nettype wire
